[sv/lcdnw_pkg.sv]
// Shared types, codes and constants of the character LCD nibble write sequencer.
// Used by lcdnw_ctrl, lcdnw_dp and the top level; depends on nothing.
package lcdnw_pkg;

    // Request codes
    localparam logic [2:0] ReqInit     = 3'd0;
    localparam logic [2:0] ReqCmdByte  = 3'd1;
    localparam logic [2:0] ReqDataByte = 3'd2;
    localparam logic [2:0] ReqGoto     = 3'd3;
    localparam logic [2:0] ReqGlyph    = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CfgEnablePulse  = 2'd0;
    localparam logic [1:0] CfgDataSettle   = 2'd1;
    localparam logic [1:0] CfgCommandSettle = 2'd2;

    localparam logic [7:0]  EnablePulseReset   = 8'd10;
    localparam logic [15:0] DataSettleReset    = 16'd200;
    localparam logic [15:0] CommandSettleReset = 16'd2000;

    localparam logic [15:0] InitWaitUs   = 16'd40000;
    localparam logic [15:0] ClearExtraUs = 16'd2000;
    localparam logic [7:0]  HighNibbleMask = 8'hF0;

    // Byte counter limits within a request
    localparam logic [3:0] InitLastIdx  = 4'd5;
    localparam logic [3:0] GlyphDataLastIdx = 4'd8;
    localparam logic [3:0] GlyphGotoIdx = 4'd9;
    localparam logic [3:0] GlyphLastIdx = 4'd10;
    // Init byte that clears the display and gets the extra wait
    localparam logic [2:0] InitClearIdx = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WAIT,
        ST_BYTE
    } ctrl_state_t;

    typedef enum logic [2:0] {
        SRC_INIT,
        SRC_VALUE_CMD,
        SRC_VALUE_DATA,
        SRC_GOTO,
        SRC_SLOT_ADDR,
        SRC_GLYPH,
        SRC_SLOT_DATA
    } byte_src_t;

    // Controller to datapath
    typedef struct packed {
        logic      load_req;   // latch the accepted item
        logic      emit;       // load one pin state into the output register
        logic      wait_state; // emitted pin state is the power-up wait
        byte_src_t src;
        logic [2:0] k;         // init or glyph byte number
        logic [1:0] phase;     // 0 hi E=1, 1 hi E=0, 2 lo E=1, 3 lo E=0
        logic      last;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] req_cmd;
        logic       row_ok;
        logic       out_free;
    } dp_status_t;

    function automatic logic [7:0] init_byte(input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = 8'h33;
            3'd1:    b = 8'h32;
            3'd2:    b = 8'h28;
            3'd3:    b = 8'h0C;
            3'd4:    b = 8'h01;
            default: b = 8'h06;
        endcase
        return b;
    endfunction

endpackage

[sv/char_lcd_nibble_write_sequencer.sv]
// Top level of the character LCD 4-bit write sequencer.
// Uses lcdnw_pkg; instantiates lcdnw_ctrl and lcdnw_dp.
//
// Usage:
//   s_* channel (valid/ready): one request item (init, command byte, data byte,
//   go-to, glyph load). m_* channel (valid/ready): one pin state per item
//   (RS, E, port byte, hold time in us), m_last marks the final one of a request.
//   cfg_write/cfg_index/cfg_wdata: 0 enable pulse, 1 data settle, 2 command
//   settle; write only while idle.
//   A taken request is decoded before its first pin state is loaded.
//   Throughput: one pin state per cycle while m_ready stays high; a request that
//   makes n pin states (0 to 44) emits them all before the next item is
//   taken. The sequencer's byte/phase counter sets this rate.
//   s_ready is high only between requests; the last pin state may still wait in
//   the output register while the next item is taken.
//   A stall on m_ready holds the output register and freezes the sequencer.
//   Reset (aresetn low, synchronous) empties the output, returns to idle and
//   restores the timing registers to 10, 200 and 2000 us.
module char_lcd_nibble_write_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [7:0]  s_byte_value,
    input  logic [1:0]  s_row,
    input  logic [5:0]  s_column,
    input  logic [2:0]  s_cgram_slot,
    input  logic [63:0] s_glyph_rows,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_reg_select,
    output logic        m_enable,
    output logic [7:0]  m_port_byte,
    output logic [15:0] m_hold_us,
    output logic        m_last
);

    lcdnw_pkg::ctrl_cmd_t  cmd;
    lcdnw_pkg::dp_status_t sts;

    lcdnw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lcdnw_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_cmd        (s_cmd),
        .s_byte_value (s_byte_value),
        .s_row        (s_row),
        .s_column     (s_column),
        .s_cgram_slot (s_cgram_slot),
        .s_glyph_rows (s_glyph_rows),
        .cmd          (cmd),
        .sts          (sts),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_reg_select (m_reg_select),
        .m_enable     (m_enable),
        .m_port_byte  (m_port_byte),
        .m_hold_us    (m_hold_us),
        .m_last       (m_last)
    );

endmodule

[sv/lcdnw_ctrl.sv]
// Sequencer state machine: walks the bytes and nibble phases of one request.
// Uses lcdnw_pkg; drives the datapath lcdnw_dp through ctrl_cmd_t.
module lcdnw_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  lcdnw_pkg::dp_status_t  sts,
    output lcdnw_pkg::ctrl_cmd_t   cmd
);

    lcdnw_pkg::ctrl_state_t state_reg, state_next;
    logic [3:0] byte_idx_reg, byte_idx_next;
    logic [1:0] phase_reg, phase_next;

    lcdnw_pkg::byte_src_t plan_src;
    logic [2:0] plan_k;
    logic       plan_final;
    logic [3:0] glyph_k;

    // Which byte the counter points at, and whether it ends the request
    always_comb begin
        glyph_k    = byte_idx_reg - 4'd1;
        plan_src   = lcdnw_pkg::SRC_VALUE_CMD;
        plan_k     = 3'd0;
        plan_final = 1'b1;
        unique case (sts.req_cmd)
            lcdnw_pkg::ReqInit: begin
                plan_src   = lcdnw_pkg::SRC_INIT;
                plan_k     = byte_idx_reg[2:0];
                plan_final = (byte_idx_reg == lcdnw_pkg::InitLastIdx);
            end
            lcdnw_pkg::ReqCmdByte:  plan_src = lcdnw_pkg::SRC_VALUE_CMD;
            lcdnw_pkg::ReqDataByte: plan_src = lcdnw_pkg::SRC_VALUE_DATA;
            lcdnw_pkg::ReqGoto:     plan_src = lcdnw_pkg::SRC_GOTO;
            lcdnw_pkg::ReqGlyph: begin
                plan_final = 1'b0;
                if (byte_idx_reg == 4'd0) begin
                    plan_src = lcdnw_pkg::SRC_SLOT_ADDR;
                end else if (byte_idx_reg <= lcdnw_pkg::GlyphDataLastIdx) begin
                    plan_src = lcdnw_pkg::SRC_GLYPH;
                    plan_k   = glyph_k[2:0];
                end else if (byte_idx_reg == lcdnw_pkg::GlyphGotoIdx && sts.row_ok) begin
                    plan_src = lcdnw_pkg::SRC_GOTO;
                end else begin
                    plan_src   = lcdnw_pkg::SRC_SLOT_DATA;
                    plan_final = 1'b1;
                end
            end
            default: plan_final = 1'b1;
        endcase
    end

    // Next state and counters
    always_comb begin
        state_next    = state_reg;
        byte_idx_next = byte_idx_reg;
        phase_next    = phase_reg;
        unique case (state_reg)
            lcdnw_pkg::ST_IDLE: begin
                if (s_valid) state_next = lcdnw_pkg::ST_DECODE;
            end
            lcdnw_pkg::ST_DECODE: begin
                byte_idx_next = 4'd0;
                phase_next    = 2'd0;
                case (sts.req_cmd)
                    lcdnw_pkg::ReqInit: state_next = lcdnw_pkg::ST_WAIT;
                    lcdnw_pkg::ReqCmdByte,
                    lcdnw_pkg::ReqDataByte,
                    lcdnw_pkg::ReqGlyph: state_next = lcdnw_pkg::ST_BYTE;
                    lcdnw_pkg::ReqGoto:
                        state_next = sts.row_ok ? lcdnw_pkg::ST_BYTE : lcdnw_pkg::ST_IDLE;
                    default: state_next = lcdnw_pkg::ST_IDLE;
                endcase
            end
            lcdnw_pkg::ST_WAIT: begin
                if (sts.out_free) state_next = lcdnw_pkg::ST_BYTE;
            end
            lcdnw_pkg::ST_BYTE: begin
                if (sts.out_free) begin
                    phase_next = phase_reg + 2'd1;
                    if (phase_reg == 2'd3) begin
                        if (plan_final) state_next = lcdnw_pkg::ST_IDLE;
                        else byte_idx_next = byte_idx_reg + 4'd1;
                    end
                end
            end
            default: state_next = lcdnw_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready        = (state_reg == lcdnw_pkg::ST_IDLE);
        cmd.load_req   = s_valid && (state_reg == lcdnw_pkg::ST_IDLE);
        cmd.emit       = 1'b0;
        cmd.wait_state = 1'b0;
        cmd.src        = plan_src;
        cmd.k          = plan_k;
        cmd.phase      = phase_reg;
        cmd.last       = 1'b0;
        unique case (state_reg)
            lcdnw_pkg::ST_IDLE, lcdnw_pkg::ST_DECODE: ;
            lcdnw_pkg::ST_WAIT: begin
                cmd.emit       = sts.out_free;
                cmd.wait_state = 1'b1;
            end
            lcdnw_pkg::ST_BYTE: begin
                cmd.emit = sts.out_free;
                cmd.last = plan_final && (phase_reg == 2'd3);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lcdnw_pkg::ST_IDLE;
            byte_idx_reg <= 4'd0;
            phase_reg    <= 2'd0;
        end else begin
            state_reg    <= state_next;
            byte_idx_reg <= byte_idx_next;
            phase_reg    <= phase_next;
        end
    end

    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("pin state emitted into a full output register");

    a_last_ends_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.last) |=> (state_reg == lcdnw_pkg::ST_IDLE))
        else $error("sequencer kept running after the final pin state");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lcdnw_pkg::ST_BYTE) |-> (byte_idx_reg <= lcdnw_pkg::GlyphLastIdx))
        else $error("byte counter ran past the longest request");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_req |=> (state_reg == lcdnw_pkg::ST_DECODE && !s_ready))
        else $error("item accepted while a request was in progress");

endmodule

[sv/lcdnw_dp.sv]
// Datapath: config registers, latched request, byte/nibble selection and output register.
// Uses lcdnw_pkg; controlled by lcdnw_ctrl through ctrl_cmd_t.
module lcdnw_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_wdata,
    input  logic [2:0]            s_cmd,
    input  logic [7:0]            s_byte_value,
    input  logic [1:0]            s_row,
    input  logic [5:0]            s_column,
    input  logic [2:0]            s_cgram_slot,
    input  logic [63:0]           s_glyph_rows,
    input  lcdnw_pkg::ctrl_cmd_t  cmd,
    output lcdnw_pkg::dp_status_t sts,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_reg_select,
    output logic                  m_enable,
    output logic [7:0]            m_port_byte,
    output logic [15:0]           m_hold_us,
    output logic                  m_last
);

    logic [7:0]  enable_pulse_reg;
    logic [15:0] data_settle_reg;
    logic [15:0] command_settle_reg;

    logic [2:0]  req_cmd_reg;
    logic [7:0]  byte_value_reg;
    logic [1:0]  row_reg;
    logic [5:0]  column_reg;
    logic [2:0]  slot_reg;
    logic [63:0] glyph_reg;

    logic        m_valid_reg, m_valid_next;
    logic        rs_reg, en_reg, last_reg;
    logic [7:0]  port_reg;
    logic [15:0] hold_reg;

    logic [7:0]  cur_byte;
    logic        cur_rs;
    logic [16:0] clear_sum;
    logic [15:0] final_hold;
    logic        rs_next, en_next;
    logic [7:0]  port_next;
    logic [15:0] hold_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_pulse_reg   <= lcdnw_pkg::EnablePulseReset;
            data_settle_reg    <= lcdnw_pkg::DataSettleReset;
            command_settle_reg <= lcdnw_pkg::CommandSettleReset;
        end else if (cfg_write) begin
            case (cfg_index)
                lcdnw_pkg::CfgEnablePulse:   enable_pulse_reg   <= cfg_wdata[7:0];
                lcdnw_pkg::CfgDataSettle:    data_settle_reg    <= cfg_wdata;
                lcdnw_pkg::CfgCommandSettle: command_settle_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_cmd_reg    <= s_cmd;
            byte_value_reg <= s_byte_value;
            row_reg        <= s_row;
            column_reg     <= s_column;
            slot_reg       <= s_cgram_slot;
            glyph_reg      <= s_glyph_rows;
        end
    end

    // Byte being sent and its RS level
    always_comb begin
        unique case (cmd.src)
            lcdnw_pkg::SRC_INIT:       cur_byte = lcdnw_pkg::init_byte(cmd.k);
            lcdnw_pkg::SRC_VALUE_CMD,
            lcdnw_pkg::SRC_VALUE_DATA: cur_byte = byte_value_reg;
            // row 0 -> 0x80 + column, row 1 -> 0xC0 + column
            lcdnw_pkg::SRC_GOTO:       cur_byte = {1'b1, row_reg[0], column_reg};
            lcdnw_pkg::SRC_SLOT_ADDR:  cur_byte = {2'b01, slot_reg, 3'b000};
            lcdnw_pkg::SRC_GLYPH:      cur_byte = glyph_reg[{cmd.k, 3'b000} +: 8];
            lcdnw_pkg::SRC_SLOT_DATA:  cur_byte = {5'd0, slot_reg};
            default:                   cur_byte = 8'd0;
        endcase
        case (cmd.src)
            lcdnw_pkg::SRC_VALUE_DATA,
            lcdnw_pkg::SRC_GLYPH,
            lcdnw_pkg::SRC_SLOT_DATA: cur_rs = 1'b1;
            default:                  cur_rs = 1'b0;
        endcase
    end

    // Final hold of a byte; the init sequence's display clear waits longer, saturated
    always_comb begin
        clear_sum = {1'b0, command_settle_reg} + {1'b0, lcdnw_pkg::ClearExtraUs};
        if (cur_rs)
            final_hold = data_settle_reg;
        else if (cmd.src == lcdnw_pkg::SRC_INIT && cmd.k == lcdnw_pkg::InitClearIdx)
            final_hold = clear_sum[16] ? 16'hFFFF : clear_sum[15:0];
        else
            final_hold = command_settle_reg;
    end

    always_comb begin
        if (cmd.wait_state) begin
            rs_next   = 1'b0;
            en_next   = 1'b0;
            port_next = 8'd0;
            hold_next = lcdnw_pkg::InitWaitUs;
        end else begin
            rs_next   = cur_rs;
            en_next   = !cmd.phase[0];
            port_next = cmd.phase[1] ? {cur_byte[3:0], 4'h0}
                                     : (cur_byte & lcdnw_pkg::HighNibbleMask);
            case (cmd.phase)
                2'd1:    hold_next = data_settle_reg;
                2'd3:    hold_next = final_hold;
                default: hold_next = {8'd0, enable_pulse_reg};
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit)
            m_valid_next = 1'b1;
        else if (m_ready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            rs_reg   <= rs_next;
            en_reg   <= en_next;
            port_reg <= port_next;
            hold_reg <= hold_next;
            last_reg <= cmd.last;
        end
    end

    assign sts.req_cmd  = req_cmd_reg;
    assign sts.row_ok   = !row_reg[1];
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_reg_select = rs_reg;
    assign m_enable     = en_reg;
    assign m_port_byte  = port_reg;
    assign m_hold_us    = hold_reg;
    assign m_last       = last_reg;

endmodule

[dv/lcdnw_checker.sv]
// Checker for the LCD nibble write sequencer: predicts pin states per request and compares.
// Watches the request, result and timing register ports; depends on lcdnw_pkg.
module lcdnw_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [7:0]  s_byte_value,
    input  logic [1:0]  s_row,
    input  logic [5:0]  s_column,
    input  logic [2:0]  s_cgram_slot,
    input  logic [63:0] s_glyph_rows,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_reg_select,
    input  logic        m_enable,
    input  logic [7:0]  m_port_byte,
    input  logic [15:0] m_hold_us,
    input  logic        m_last,
    output int          outstanding,
    output int          checked,
    output int          errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0]  SetDdramAddr = 8'h80;
    localparam logic [7:0]  Row1Base     = 8'h40;
    localparam logic [7:0]  SetCgramAddr = 8'h40;
    localparam logic [47:0] InitSeq      = 48'h33_32_28_0C_01_06;
    localparam int          MaxPrinted   = 30;

    typedef struct packed {
        logic        rs;
        logic        en;
        logic [7:0]  port;
        logic [15:0] hold;
        logic        last;
    } pin_t;

    pin_t        pins_due[$];
    pin_t        held_pin;
    bit          have_held;
    logic [7:0]  pulse_us;
    logic [15:0] data_us;
    logic [15:0] cmd_us;

    initial begin
        outstanding = 0;
        checked = 0;
        errors = 0;
        have_held = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= MaxPrinted)
            $display("[%0t] pin state %0d: %s got 0x%0h want 0x%0h", $realtime, checked, what,
                     got, want);
    endtask

    // One pin state is held back so the request's final one can be tagged last.
    task automatic queue_pin(input logic rs, input logic en, input logic [7:0] port,
                             input logic [15:0] hold);
        if (have_held)
            pins_due.push_back(held_pin);
        held_pin.rs = rs;
        held_pin.en = en;
        held_pin.port = port;
        held_pin.hold = hold;
        held_pin.last = 1'b0;
        have_held = 1'b1;
    endtask

    task automatic queue_byte(input logic rs, input logic [7:0] value, input logic [15:0] extra);
        logic [16:0] tail;
        logic [15:0] tail_hold;
        tail = (rs ? {1'b0, data_us} : {1'b0, cmd_us}) + {1'b0, extra};
        tail_hold = tail[16] ? 16'hFFFF : tail[15:0];
        queue_pin(rs, 1'b1, value & lcdnw_pkg::HighNibbleMask, {8'h00, pulse_us});
        queue_pin(rs, 1'b0, value & lcdnw_pkg::HighNibbleMask, data_us);
        queue_pin(rs, 1'b1, {value[3:0], 4'h0}, {8'h00, pulse_us});
        queue_pin(rs, 1'b0, {value[3:0], 4'h0}, tail_hold);
    endtask

    // Rows 2 and 3 have no DDRAM base, so nothing goes out.
    task automatic queue_goto(input logic [1:0] row, input logic [5:0] col);
        if (row == 2'd0)
            queue_byte(1'b0, SetDdramAddr + {2'b00, col}, 16'd0);
        else if (row == 2'd1)
            queue_byte(1'b0, SetDdramAddr + Row1Base + {2'b00, col}, 16'd0);
    endtask

    task automatic expand_request(input logic [2:0] cmd, input logic [7:0] value,
                                  input logic [1:0] row, input logic [5:0] col,
                                  input logic [2:0] slot, input logic [63:0] glyph);
        case (cmd)
            lcdnw_pkg::ReqInit: begin
                queue_pin(1'b0, 1'b0, 8'h00, lcdnw_pkg::InitWaitUs);
                for (int k = 0; k < 6; k++)
                    queue_byte(1'b0, InitSeq[47 - 8 * k -: 8],
                               (k == int'(lcdnw_pkg::InitClearIdx)) ? lcdnw_pkg::ClearExtraUs
                                                                    : 16'd0);
            end
            lcdnw_pkg::ReqCmdByte:  queue_byte(1'b0, value, 16'd0);
            lcdnw_pkg::ReqDataByte: queue_byte(1'b1, value, 16'd0);
            lcdnw_pkg::ReqGoto:     queue_goto(row, col);
            lcdnw_pkg::ReqGlyph: begin
                queue_byte(1'b0, SetCgramAddr + {2'b00, slot, 3'b000}, 16'd0);
                for (int k = 0; k < 8; k++)
                    queue_byte(1'b1, glyph[8 * k +: 8], 16'd0);
                queue_goto(row, col);
                queue_byte(1'b1, {5'b00000, slot}, 16'd0);
            end
            default: ;
        endcase
        if (have_held) begin
            held_pin.last = 1'b1;
            pins_due.push_back(held_pin);
            have_held = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        pin_t want;
        if (!aresetn) begin
            pins_due.delete();
            have_held = 1'b0;
            pulse_us = lcdnw_pkg::EnablePulseReset;
            data_us = lcdnw_pkg::DataSettleReset;
            cmd_us = lcdnw_pkg::CommandSettleReset;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    lcdnw_pkg::CfgEnablePulse:   pulse_us = cfg_wdata[7:0];
                    lcdnw_pkg::CfgDataSettle:    data_us = cfg_wdata;
                    lcdnw_pkg::CfgCommandSettle: cmd_us = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expand_request(s_cmd, s_byte_value, s_row, s_column, s_cgram_slot,
                               s_glyph_rows);
            if (m_valid && m_ready) begin
                if (pins_due.size() == 0) begin
                    report_mismatch("unexpected pin state, port", m_port_byte, 0);
                end else begin
                    want = pins_due.pop_front();
                    if (m_reg_select !== want.rs)
                        report_mismatch("reg_select", m_reg_select, want.rs);
                    if (m_enable !== want.en)
                        report_mismatch("enable", m_enable, want.en);
                    if (m_port_byte !== want.port)
                        report_mismatch("port_byte", m_port_byte, want.port);
                    if (m_hold_us !== want.hold)
                        report_mismatch("hold_us", m_hold_us, want.hold);
                    if (m_last !== want.last)
                        report_mismatch("last", m_last, want.last);
                    checked++;
                end
            end
        end
        outstanding <= pins_due.size();
    end

endmodule

[dv/tb_top.sv]
// Top of the LCD nibble write sequencer testbench: clock, reset, requests and verdict.
// Instantiates char_lcd_nibble_write_sequencer and lcdnw_checker; depends on lcdnw_pkg.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit    = 500_000;
    localparam int ItemsPerPhase = 60;
    localparam int NumPhases     = 5;
    localparam int SettleCycles  = 8;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = lcdnw_pkg::CfgEnablePulse;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_cmd = lcdnw_pkg::ReqInit;
    logic [7:0]  s_byte_value = 8'd0;
    logic [1:0]  s_row = 2'd0;
    logic [5:0]  s_column = 6'd0;
    logic [2:0]  s_cgram_slot = 3'd0;
    logic [63:0] s_glyph_rows = 64'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_reg_select;
    logic        m_enable;
    logic [7:0]  m_port_byte;
    logic [15:0] m_hold_us;
    logic        m_last;
    int          outstanding;
    int          checked;
    int          errors;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int cycles = 0;
    int active_items = 0;
    int silent_items = 0;

    char_lcd_nibble_write_sequencer uut (.*);
    lcdnw_checker chk (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("timeout after %0d cycles, %0d pin states still due", cycles, outstanding);
            $display("char_lcd_nibble_write_sequencer verification failed");
            $finish;
        end
    end

    task automatic send_req(input logic [2:0] cmd, input logic [7:0] value,
                            input logic [1:0] row, input logic [5:0] col,
                            input logic [2:0] slot, input logic [63:0] glyph);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_byte_value <= value;
        s_row <= row;
        s_column <= col;
        s_cgram_slot <= slot;
        s_glyph_rows <= glyph;
        do @(posedge aclk); while (!s_ready);
        if (cmd > lcdnw_pkg::ReqGlyph || (cmd == lcdnw_pkg::ReqGoto && row > 2'd1))
            silent_items++;
        else
            active_items++;
    endtask

    // Hold off the sender until every pin state is out, then let a silent request finish.
    task automatic drain;
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic retime(input int phase);
        logic [15:0] pulse, data, cmd;
        case (phase)
            1: begin
                pulse = 16'd255;
                data = 16'hFFFF;
                cmd = 16'hFFFF;
            end
            2: begin
                // upper bits must be dropped by the 8-bit pulse register
                pulse = 16'hFF00;
                data = 16'd0;
                cmd = 16'd0;
            end
            3: begin
                pulse = 16'($urandom);
                data = 16'($urandom);
                cmd = ($urandom_range(2) == 0) ? 16'(65535 - $urandom_range(1999))
                                               : 16'($urandom);
            end
            default: begin
                pulse = 16'd1;
                data = 16'd1;
                cmd = 16'd1;
            end
        endcase
        write_reg(lcdnw_pkg::CfgEnablePulse, pulse);
        write_reg(lcdnw_pkg::CfgDataSettle, data);
        write_reg(lcdnw_pkg::CfgCommandSettle, cmd);
        cfg_write <= 1'b0;
    endtask

    task automatic run_directed;
        send_req(lcdnw_pkg::ReqInit, 8'h00, 2'd0, 6'd0, 3'd0, 64'd0);
        send_req(lcdnw_pkg::ReqCmdByte, 8'h00, 2'd0, 6'd0, 3'd0, 64'd0);
        send_req(lcdnw_pkg::ReqCmdByte, 8'hFF, 2'd3, 6'd63, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        send_req(lcdnw_pkg::ReqDataByte, 8'h00, 2'd0, 6'd0, 3'd0, 64'd0);
        send_req(lcdnw_pkg::ReqDataByte, 8'hFF, 2'd0, 6'd0, 3'd0, 64'd0);
        send_req(lcdnw_pkg::ReqDataByte, 8'hA5, 2'd0, 6'd0, 3'd0, 64'd0);
        send_req(lcdnw_pkg::ReqGoto, 8'h00, 2'd0, 6'd0, 3'd0, 64'd0);
        send_req(lcdnw_pkg::ReqGoto, 8'h00, 2'd0, 6'd63, 3'd0, 64'd0);
        send_req(lcdnw_pkg::ReqGoto, 8'h00, 2'd1, 6'd0, 3'd0, 64'd0);
        send_req(lcdnw_pkg::ReqGoto, 8'h00, 2'd1, 6'd63, 3'd0, 64'd0);
        send_req(lcdnw_pkg::ReqGoto, 8'h00, 2'd2, 6'd12, 3'd0, 64'd0);
        send_req(lcdnw_pkg::ReqGoto, 8'h00, 2'd3, 6'd63, 3'd0, 64'd0);
        send_req(lcdnw_pkg::ReqGlyph, 8'h00, 2'd0, 6'd0, 3'd0, 64'd0);
        send_req(lcdnw_pkg::ReqGlyph, 8'hFF, 2'd1, 6'd63, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        send_req(lcdnw_pkg::ReqGlyph, 8'h00, 2'd2, 6'd5, 3'd3, 64'h0123_4567_89AB_CDEF);
        send_req(lcdnw_pkg::ReqGlyph, 8'h00, 2'd3, 6'd40, 3'd5, 64'h1F11_0A04_0A11_1F00);
        send_req(lcdnw_pkg::ReqGlyph + 3'd1, 8'h12, 2'd0, 6'd1, 3'd1, 64'd1);
        send_req(lcdnw_pkg::ReqGlyph + 3'd2, 8'h34, 2'd1, 6'd2, 3'd2, 64'd2);
        send_req(3'd7, 8'h56, 2'd2, 6'd3, 3'd3, 64'd3);
        send_req(lcdnw_pkg::ReqInit, 8'hFF, 2'd3, 6'd63, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    task automatic random_request;
        logic [2:0] cmd;
        logic [1:0] row;
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            cmd = lcdnw_pkg::ReqInit;
        else if (pick < 26)
            cmd = lcdnw_pkg::ReqCmdByte;
        else if (pick < 46)
            cmd = lcdnw_pkg::ReqDataByte;
        else if (pick < 66)
            cmd = lcdnw_pkg::ReqGoto;
        else if (pick < 94)
            cmd = lcdnw_pkg::ReqGlyph;
        else
            cmd = 3'($urandom_range(7, lcdnw_pkg::ReqGlyph + 1));
        // mostly rows that have an address
        row = ($urandom_range(9) == 0) ? 2'(2 + $urandom_range(1)) : 2'($urandom_range(1));
        send_req(cmd, 8'($urandom), row, 6'($urandom), 3'($urandom),
                 {$urandom, $urandom});
    endtask

    initial begin
        int goal;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        for (int phase = 0; phase < NumPhases; phase++) begin
            if (phase > 0) begin
                drain;
                retime(phase);
            end
            case (phase)
                1:       begin send_idle_pct = 65; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 65; end
                3:       begin send_idle_pct = 37; stall_pct = 37; end
                default: begin send_idle_pct = 0;  stall_pct = 0;  end
            endcase
            if (phase == 0)
                run_directed();
            goal = active_items + ItemsPerPhase;
            while (active_items < goal)
                random_request();
        end
        drain;
        $display("sent %0d requests with pin states and %0d with none, over %0d timing settings",
                 active_items, silent_items, NumPhases);
        $display("checked %0d pin states under mixed sender gaps and receiver stalls", checked);
        if (errors == 0 && outstanding == 0)
            $display("char_lcd_nibble_write_sequencer verification clean");
        else
            $display("char_lcd_nibble_write_sequencer verification failed");
        $finish;
    end

endmodule

[filelist.f]
sv/lcdnw_pkg.sv
sv/lcdnw_ctrl.sv
sv/lcdnw_dp.sv
sv/char_lcd_nibble_write_sequencer.sv
dv/lcdnw_checker.sv
dv/tb_top.sv
